>>> hw/rtl/crcfp_pkg.sv
// crcfp_pkg: shared types and constants for the crc32 framed packet parser
// no dependencies; used by the channel interfaces, crcfp_in_reg and crcfp_core
`timescale 1ns / 1ps

package crcfp_pkg;

  localparam logic [7:0]  SyncA       = 8'hAA;
  localparam logic [7:0]  SyncB       = 8'h44;
  localparam logic [7:0]  SyncC       = 8'h12;
  localparam logic [31:0] CrcPoly     = 32'hEDB88320;
  localparam logic [15:0] MinFrameLen = 16'd6;
  localparam logic [15:0] MaxLenReset = 16'd156;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic [15:0] frame_length;
  } out_t;

  typedef struct packed {
    logic [15:0] max_frame_len;
  } cfg_t;

endpackage

>>> hw/rtl/crcfp_ifs.sv
// crcfp channel interfaces: byte input, result output, configuration write
// depends on crcfp_pkg for the payload types
`timescale 1ns / 1ps

interface crcfp_in_if;
  logic            valid;
  logic            ready;
  crcfp_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crcfp_out_if;
  logic            valid;
  logic            ready;
  crcfp_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crcfp_cfg_if;
  logic            valid;
  logic            ready;
  crcfp_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/crc32_framed_packet_parser.sv
// crc32_framed_packet_parser: byte-serial sync/length frame parser, crc-32 check
// a byte transfer shows its result through the input register, then the result register
// throughput: one byte per cycle unless out_if stalls, set by the single-byte crc update and
// the phase register; a new byte is taken while an earlier result still waits on the output
// reset (rst_ni low, asynchronous): hunting for sync, crc and counts cleared, max length 156
// depends on crcfp_pkg, crcfp_ifs, crcfp_in_reg and crcfp_core
`timescale 1ns / 1ps

module crc32_framed_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcfp_in_if.sink    in_if,
  crcfp_out_if.source out_if,
  crcfp_cfg_if.sink   cfg_if
);

  crcfp_in_if byte_if ();

  crcfp_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (byte_if)
  );

  crcfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (byte_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

endmodule

>>> hw/rtl/crcfp_in_reg.sv
// crcfp_in_reg: input register stage for received bytes
// depends on crcfp_pkg and crcfp_in_if
`timescale 1ns / 1ps

module crcfp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  crcfp_in_if.sink   in_if,
  crcfp_in_if.source out_if
);

  logic           valid_d, valid_q;
  crcfp_pkg::in_t data_q;
  logic           load;

  // refill in the same cycle the held byte moves on
  assign in_if.ready = !valid_q || out_if.ready;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_if.ready) begin
      valid_d = in_if.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_if.data;
    end
  end

  assign out_if.valid = valid_q;
  assign out_if.data  = data_q;

endmodule

>>> hw/rtl/crcfp_core.sv
// crcfp_core: sync hunt, length check, crc-32 update and result register
// depends on crcfp_pkg, crcfp_in_if, crcfp_out_if and crcfp_cfg_if
`timescale 1ns / 1ps

module crcfp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcfp_in_if.sink    in_if,
  crcfp_out_if.source out_if,
  crcfp_cfg_if.sink   cfg_if
);

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_WANT_B = 7'b0000010,
    PH_WANT_C = 7'b0000100,
    PH_LEN_LO = 7'b0001000,
    PH_LEN_HI = 7'b0010000,
    PH_BODY   = 7'b0100000,
    PH_CRC    = 7'b1000000
  } phase_e;

  // reflected crc-32 over one byte, bitwise over the low byte only
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] t;
    t = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ crcfp_pkg::CrcPoly) : (t >> 1);
    end
    return {8'h0, crc[31:8]} ^ t;
  endfunction

  phase_e      phase_d, phase_q;
  logic [15:0] len_d, len_q;
  logic [15:0] taken_d, taken_q;
  logic [31:0] crc_d, crc_q;
  logic [31:0] rx_crc_d, rx_crc_q;
  logic [1:0]  crc_cnt_d, crc_cnt_q;
  logic [15:0] max_len_q;

  logic            out_valid_d, out_valid_q;
  crcfp_pkg::out_t out_q;
  crcfp_pkg::out_t res;
  logic            res_valid;

  logic        out_free;
  logic        fire;
  logic [7:0]  b;
  logic [15:0] len_new;
  logic [31:0] rx_new;

  assign out_free    = !out_valid_q || out_if.ready;
  assign fire        = in_if.valid && out_free;
  assign in_if.ready = out_free;
  assign b           = in_if.data.data_byte;
  assign len_new     = {b, len_q[7:0]};
  assign rx_new      = rx_crc_q | ({24'h0, b} << {crc_cnt_q, 3'b000});

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    taken_d   = taken_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    crc_cnt_d = crc_cnt_q;
    res       = '0;
    res_valid = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PH_WANT_B: begin
          crc_d   = crc_byte(crc_q, b);
          taken_d = taken_q + 16'd1;
          phase_d = (b == crcfp_pkg::SyncB) ? PH_WANT_C : PH_HUNT;
        end
        PH_WANT_C: begin
          crc_d   = crc_byte(crc_q, b);
          taken_d = taken_q + 16'd1;
          phase_d = (b == crcfp_pkg::SyncC) ? PH_LEN_LO : PH_HUNT;
        end
        PH_LEN_LO: begin
          crc_d   = crc_byte(crc_q, b);
          taken_d = taken_q + 16'd1;
          len_d   = {8'h00, b};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len_new > max_len_q || len_new < crcfp_pkg::MinFrameLen) begin
            // out of bounds: drop the frame silently
            phase_d   = PH_HUNT;
            len_d     = '0;
            taken_d   = '0;
            crc_d     = '0;
            rx_crc_d  = '0;
            crc_cnt_d = '0;
          end else begin
            crc_d   = crc_byte(crc_q, b);
            taken_d = taken_q + 16'd1;
            len_d   = len_new;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          crc_d   = crc_byte(crc_q, b);
          taken_d = taken_q + 16'd1;
          if (taken_q + 16'd1 == len_q) begin
            phase_d = PH_CRC;
          end
          res_valid        = 1'b1;
          res.result_kind  = crcfp_pkg::KIND_BODY;
          res.body_byte    = b;
          res.body_index   = taken_q;
          res.frame_length = len_q;
        end
        PH_CRC: begin
          rx_crc_d = rx_new;
          if (crc_cnt_q != 2'd3) begin
            crc_cnt_d = crc_cnt_q + 2'd1;
          end else begin
            res_valid        = 1'b1;
            res.result_kind  = (rx_new == crc_q) ? crcfp_pkg::KIND_GOOD
                                                 : crcfp_pkg::KIND_BAD;
            res.frame_length = len_q;
            phase_d   = PH_HUNT;
            len_d     = '0;
            taken_d   = '0;
            crc_d     = '0;
            rx_crc_d  = '0;
            crc_cnt_d = '0;
          end
        end
        default: begin
          // hunting: only the first sync byte starts a frame
          if (b == crcfp_pkg::SyncA) begin
            phase_d   = PH_WANT_B;
            len_d     = '0;
            taken_d   = 16'd1;
            crc_d     = crc_byte(32'h0, b);
            rx_crc_d  = '0;
            crc_cnt_d = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      len_q       <= '0;
      taken_q     <= '0;
      crc_q       <= '0;
      rx_crc_q    <= '0;
      crc_cnt_q   <= '0;
      max_len_q   <= crcfp_pkg::MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      taken_q     <= taken_d;
      crc_q       <= crc_d;
      rx_crc_q    <= rx_crc_d;
      crc_cnt_q   <= crc_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_if.valid) begin
        max_len_q <= cfg_if.data.max_frame_len;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // an accepted frame is never shorter than the minimum
  a_body_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> len_q >= crcfp_pkg::MinFrameLen)
    else $error("body phase with frame length below minimum");

  // the body always ends before the byte count reaches the length
  a_body_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> taken_q < len_q)
    else $error("body byte count overran frame length");

  // the fourth crc byte closes the frame
  a_crc_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PH_CRC && crc_cnt_q == 2'd3 |=> phase_q == PH_HUNT)
    else $error("frame not closed after last crc byte");

  a_crc_cnt_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_cnt_q != 2'd0 |-> phase_q == PH_CRC)
    else $error("crc byte count set outside crc phase");

  a_out_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_kind == crcfp_pkg::KIND_BODY
      |-> out_q.body_index < out_q.frame_length)
    else $error("body index not below frame length");

endmodule
